// File: rtl/primitive_to_vertex_expander_defines.svh
// ----------------------------------------------------------------------------
// Primitive to vertex expander assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_TO_VERTEX_EXPANDER_DEFINES_SVH
`define PRIMITIVE_TO_VERTEX_EXPANDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pve_pkg.sv
// ----------------------------------------------------------------------------
// Primitive to vertex expander package
// Widths, primitive codes and the item descriptor shared by all modules.
// ----------------------------------------------------------------------------
package pve_pkg;

   localparam int COORD_W        = 16;
   localparam int WIDE_W         = 17;
   localparam int FUNC_W         = 3;
   localparam int INDEX_BITS     = 20;
   localparam int VERTEX_INDEX_W = 20;
   localparam int MAX_VERTS      = 4;
   localparam int SEL_W          = $clog2(MAX_VERTS);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FUNC_W-1:0] FUNC_RECT       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_BOX        = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SPAN       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LINE_POINT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SEGMENT    = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } vertex_type;

   typedef struct packed {
      vertex_type [MAX_VERTS-1:0] vert;
      logic [SEL_W-1:0]           last_sel;
   } item_type;

endpackage

// File: rtl/pve_front.sv
// ----------------------------------------------------------------------------
// Primitive to vertex expander front end
// Accepts primitives, tracks the line-strip point and builds vertex lists.
// ----------------------------------------------------------------------------
module pve_front
   import pve_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [COORD_W-1:0] req_coord_a,
   input  logic signed [COORD_W-1:0] req_coord_b,
   input  logic signed [WIDE_W-1:0]  req_coord_c,
   input  logic signed [WIDE_W-1:0]  req_coord_d,
   input  logic                      req_relative_mode,
   input  logic                      req_strip_loop,
   input  logic                      req_first_point,
   input  logic                      req_last_point,
   input  logic                      queue_full,
   output logic                      push_valid,
   output item_type                  push_item
);

   logic [COORD_W-1:0] pt_x_ff, pt_y_ff, pt_x_in, pt_y_in;
   logic [COORD_W-1:0] c16, d16, rect_x2, rect_y2, span_x2;
   logic [COORD_W-1:0] base_x, base_y, px, py;
   logic               accept, has_verts;

   function automatic logic [COORD_W-1:0] adjust_end(input logic signed [COORD_W-1:0] s,
                                                     input logic signed [COORD_W-1:0] e,
                                                     input logic pointlike);
      logic [COORD_W-1:0] r;
      r = e;
      if (e > s) begin
         r = e + COORD_W'(1);
      end else if (e < s) begin
         r = e - COORD_W'(1);
      end else if (pointlike) begin
         r = e + COORD_W'(1);
      end
      return r;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign c16     = req_coord_c[COORD_W-1:0];
   assign d16     = req_coord_d[COORD_W-1:0];
   assign rect_x2 = req_coord_a + c16;
   assign rect_y2 = req_coord_b + d16;
   assign span_x2 = req_coord_a + c16 + COORD_W'(1);

   assign base_x = req_first_point ? '0 : pt_x_ff;
   assign base_y = req_first_point ? '0 : pt_y_ff;
   assign px     = req_relative_mode ? base_x + req_coord_a : req_coord_a;
   assign py     = req_relative_mode ? base_y + req_coord_b : req_coord_b;

   always_comb begin
      push_item = '0;
      has_verts = 1'b0;
      pt_x_in   = pt_x_ff;
      pt_y_in   = pt_y_ff;
      case (req_func)
         FUNC_RECT: begin
            push_item.vert[0]  = '{x: req_coord_a, y: req_coord_b};
            push_item.vert[1]  = '{x: rect_x2, y: req_coord_b};
            push_item.vert[2]  = '{x: rect_x2, y: rect_y2};
            push_item.vert[3]  = '{x: req_coord_a, y: rect_y2};
            push_item.last_sel = SEL_W'(3);
            has_verts          = 1'b1;
         end
         FUNC_BOX: begin
            push_item.vert[0]  = '{x: req_coord_a, y: req_coord_b};
            push_item.vert[1]  = '{x: c16, y: req_coord_b};
            push_item.vert[2]  = '{x: c16, y: d16};
            push_item.vert[3]  = '{x: req_coord_a, y: d16};
            push_item.last_sel = SEL_W'(3);
            has_verts          = 1'b1;
         end
         FUNC_SPAN: begin
            push_item.vert[0]  = '{x: req_coord_a, y: req_coord_b};
            push_item.vert[1]  = '{x: span_x2, y: req_coord_b};
            push_item.last_sel = SEL_W'(1);
            has_verts          = 1'b1;
         end
         FUNC_LINE_POINT: begin
            pt_x_in = px;
            pt_y_in = py;
            if (req_last_point && !req_strip_loop) begin
               push_item.vert[0].x = adjust_end(pt_x_ff, px, pt_y_ff == py);
               push_item.vert[0].y = adjust_end(pt_y_ff, py, 1'b0);
            end else begin
               push_item.vert[0] = '{x: px, y: py};
            end
            push_item.last_sel = '0;
            has_verts          = !(req_first_point && req_last_point);
         end
         FUNC_SEGMENT: begin
            push_item.vert[0]   = '{x: req_coord_a, y: req_coord_b};
            push_item.vert[1].x = adjust_end(req_coord_a, c16, req_coord_b == d16);
            push_item.vert[1].y = adjust_end(req_coord_b, d16, 1'b0);
            push_item.last_sel  = SEL_W'(1);
            has_verts           = 1'b1;
         end
         default: begin
            has_verts = 1'b0;
         end
      endcase
   end

   assign push_valid = accept && has_verts;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_x_ff <= '0;
         pt_y_ff <= '0;
      end else if (accept) begin
         pt_x_ff <= pt_x_in;
         pt_y_ff <= pt_y_in;
      end
   end

endmodule

// File: rtl/pve_queue.sv
// ----------------------------------------------------------------------------
// Primitive to vertex expander item queue
// Short FIFO of vertex lists between the front end and the vertex emitter.
// ----------------------------------------------------------------------------
module pve_queue
   import pve_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     queue_full,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign queue_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/pve_back.sv
// ----------------------------------------------------------------------------
// Primitive to vertex expander vertex emitter
// Walks queued vertex lists, one indexed vertex per cycle unless stalled.
// ----------------------------------------------------------------------------
module pve_back
   import pve_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  item_type                         pop_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [COORD_W-1:0]        rsp_vertex_x,
   output logic signed [COORD_W-1:0]        rsp_vertex_y,
   output logic [VERTEX_INDEX_W-1:0]        rsp_vertex_index,
   output logic                             rsp_last_of_item
);

   item_type                  cur_ff, cur_in;
   logic                      cur_valid_ff, cur_valid_in;
   logic [SEL_W-1:0]          sel_ff, sel_in;
   logic [INDEX_BITS-1:0]     count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]        rsp_x_ff, rsp_y_ff;
   logic [VERTEX_INDEX_W-1:0] rsp_index_ff;
   logic                      rsp_last_ff;
   logic                      out_free, emit, finishing, take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = cur_valid_ff && out_free;
   assign finishing = emit && (sel_ff == cur_ff.last_sel);
   assign pop_ready = !cur_valid_ff || finishing;
   assign take      = pop_ready && pop_valid;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      sel_in       = sel_ff;
      if (take) begin
         cur_in       = pop_item;
         cur_valid_in = 1'b1;
         sel_in       = '0;
      end else if (finishing) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         sel_in = sel_ff + SEL_W'(1);
      end
      count_in     = emit ? count_ff + INDEX_BITS'(1) : count_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sel_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         sel_ff       <= sel_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_x_ff     <= cur_ff.vert[sel_ff].x;
         rsp_y_ff     <= cur_ff.vert[sel_ff].y;
         rsp_index_ff <= VERTEX_INDEX_W'(count_ff);
         rsp_last_ff  <= finishing;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_x     = rsp_x_ff;
   assign rsp_vertex_y     = rsp_y_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_last_of_item = rsp_last_ff;

endmodule

// File: rtl/primitive_to_vertex_expander.sv
// ----------------------------------------------------------------------------
// Primitive to vertex expander
// Turns 2D drawing primitives into indexed integer vertices.
// ----------------------------------------------------------------------------
// The req_ channel takes one primitive per transaction: a rectangle, box,
// span, line-strip point or segment selected by req_func. The rsp_ channel
// returns its vertices in order, one per transaction, each with a running
// index and a flag on the last vertex of the primitive. Rectangles and boxes
// give four vertices, spans and segments two, a line-strip point one, and
// unknown codes or single-point strips none.
// The first vertex passes through the queue, the emitter's current-item
// register and the output register. The emitter drives one vertex per cycle
// unless rsp_ready stalls it; a two-entry queue lets the front end keep
// accepting primitives while the emitter works. When rsp_ready is low the
// vertex holds in the output register, the emitter stops, and req_ready falls
// once the queue fills. Reset clears the running line point, the vertex index
// and all valid state; req_ready is high after reset, as the queue is empty.
// ----------------------------------------------------------------------------
`include "primitive_to_vertex_expander_defines.svh"

module primitive_to_vertex_expander
   import pve_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [COORD_W-1:0] req_coord_a,
   input  logic signed [COORD_W-1:0] req_coord_b,
   input  logic signed [WIDE_W-1:0]  req_coord_c,
   input  logic signed [WIDE_W-1:0]  req_coord_d,
   input  logic                      req_relative_mode,
   input  logic                      req_strip_loop,
   input  logic                      req_first_point,
   input  logic                      req_last_point,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_vertex_x,
   output logic signed [COORD_W-1:0] rsp_vertex_y,
   output logic [VERTEX_INDEX_W-1:0] rsp_vertex_index,
   output logic                      rsp_last_of_item
);

   logic     queue_full, push_valid, pop_valid, pop_ready;
   item_type push_item, pop_item;

   pve_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_coord_a       (req_coord_a),
      .req_coord_b       (req_coord_b),
      .req_coord_c       (req_coord_c),
      .req_coord_d       (req_coord_d),
      .req_relative_mode (req_relative_mode),
      .req_strip_loop    (req_strip_loop),
      .req_first_point   (req_first_point),
      .req_last_point    (req_last_point),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_item         (push_item)
   );

   pve_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   pve_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // A primitive that is not finished keeps the output busy in the next cycle.
   `PVE_ASSERT_NEXT(a_vertex_run, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_item, rsp_valid, "vertex run of a primitive was interrupted")

   // Consecutive vertices carry consecutive indices.
   `PVE_ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && rsp_ready, !rsp_valid || (rsp_vertex_index == $past(rsp_vertex_index) + VERTEX_INDEX_W'(1)), "vertex index did not advance by one")

   // A transaction that yields vertices is accepted only when the queue has room.
   `PVE_ASSERT_NOW(a_push_room, clock, reset, push_valid, !queue_full, "vertex list pushed into a full queue")

endmodule

// File: verif/tb_primitive_to_vertex_expander.sv
// ----------------------------------------------------------------------------
// Primitive to vertex expander testbench
// Sends rectangles, boxes, spans, line strips, segments and unknown codes
// with random handshake gaps on both channels. A scoreboard predicts every
// vertex and checks each one that comes back.
// ----------------------------------------------------------------------------
module tb_primitive_to_vertex_expander;
   import pve_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_LAST_CODE = '1;

   typedef struct packed {
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic [VERTEX_INDEX_W-1:0] index;
      logic                      last_flag;
   } expected_vertex_type;

   class vertex_scoreboard;
      logic [COORD_W-1:0]        run_x, run_y, prev_x, prev_y;
      logic [VERTEX_INDEX_W-1:0] next_index;
      expected_vertex_type       pending_vertices[$];
      int                        error_count;

      function new();
         run_x = '0;
         run_y = '0;
         prev_x = '0;
         prev_y = '0;
         next_index = '0;
         error_count = 0;
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         error_count++;
      endtask

      function int pending_count();
         return pending_vertices.size();
      endfunction

      function void push_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic last_flag);
         pending_vertices.push_back('{x, y, next_index, last_flag});
         next_index++;
      endfunction

      function logic [COORD_W-1:0] end_adjust(logic signed [COORD_W-1:0] s,
                                              logic signed [COORD_W-1:0] e,
                                              bit pointlike);
         if (e > s) begin
            return e + 16'sd1;
         end else if (e < s) begin
            return e - 16'sd1;
         end else if (pointlike) begin
            return e + 16'sd1;
         end
         return e;
      endfunction

      function void note_primitive(logic [FUNC_W-1:0] func,
                                   logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                   logic [WIDE_W-1:0] c, logic [WIDE_W-1:0] d,
                                   bit rel, bit loop, bit first, bit last);
         logic [COORD_W-1:0] cx, dy, px, py, ox, oy;
         cx = c[COORD_W-1:0];
         dy = d[COORD_W-1:0];
         case (func)
            FUNC_RECT: begin
               push_vertex(a, b, 1'b0);
               push_vertex(a + cx, b, 1'b0);
               push_vertex(a + cx, b + dy, 1'b0);
               push_vertex(a, b + dy, 1'b1);
            end
            FUNC_BOX: begin
               push_vertex(a, b, 1'b0);
               push_vertex(cx, b, 1'b0);
               push_vertex(cx, dy, 1'b0);
               push_vertex(a, dy, 1'b1);
            end
            FUNC_SPAN: begin
               push_vertex(a, b, 1'b0);
               push_vertex(a + cx + 16'd1, b, 1'b1);
            end
            FUNC_LINE_POINT: begin
               if (first) begin
                  run_x = '0;
                  run_y = '0;
               end
               px = rel ? run_x + a : a;
               py = rel ? run_y + b : b;
               ox = prev_x;
               oy = prev_y;
               run_x = px;
               run_y = py;
               prev_x = px;
               prev_y = py;
               if (!(first && last)) begin
                  if (last && !loop) begin
                     push_vertex(end_adjust(ox, px, oy == py), end_adjust(oy, py, 1'b0), 1'b1);
                  end else begin
                     push_vertex(px, py, 1'b1);
                  end
               end
            end
            FUNC_SEGMENT: begin
               push_vertex(a, b, 1'b0);
               push_vertex(end_adjust(a, cx, b == dy), end_adjust(b, dy, 1'b0), 1'b1);
            end
            default: ;
         endcase
      endfunction

      task check_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                        logic [VERTEX_INDEX_W-1:0] index, logic last_flag);
         expected_vertex_type want;
         if (pending_vertices.size() == 0) begin
            report($sformatf("vertex x=%0d y=%0d index=%0d with nothing pending",
                             $signed(x), $signed(y), index));
         end else begin
            want = pending_vertices.pop_front();
            if (x !== want.x)
               report($sformatf("index %0d x got %0d want %0d", want.index, $signed(x),
                                $signed(want.x)));
            if (y !== want.y)
               report($sformatf("index %0d y got %0d want %0d", want.index, $signed(y),
                                $signed(want.y)));
            if (index !== want.index)
               report($sformatf("vertex index got %0d want %0d", index, want.index));
            if (last_flag !== want.last_flag)
               report($sformatf("index %0d last flag got %b want %b", want.index,
                                last_flag, want.last_flag));
         end
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [FUNC_W-1:0]         req_func;
   logic signed [COORD_W-1:0] req_coord_a;
   logic signed [COORD_W-1:0] req_coord_b;
   logic signed [WIDE_W-1:0]  req_coord_c;
   logic signed [WIDE_W-1:0]  req_coord_d;
   logic                      req_relative_mode;
   logic                      req_strip_loop;
   logic                      req_first_point;
   logic                      req_last_point;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [COORD_W-1:0] rsp_vertex_x;
   logic signed [COORD_W-1:0] rsp_vertex_y;
   logic [VERTEX_INDEX_W-1:0] rsp_vertex_index;
   logic                      rsp_last_of_item;

   vertex_scoreboard vertex_board;
   bit               quiet_phase;
   int               hold_off_cycles;

   primitive_to_vertex_expander u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_coord_a      (req_coord_a),
      .req_coord_b      (req_coord_b),
      .req_coord_c      (req_coord_c),
      .req_coord_d      (req_coord_d),
      .req_relative_mode(req_relative_mode),
      .req_strip_loop   (req_strip_loop),
      .req_first_point  (req_first_point),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_of_item (rsp_last_of_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

   function automatic int pick_coord();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return int'($urandom_range(0, 16)) - 8;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic int pick_wide();
      case ($urandom_range(0, 7))
         0: return 65535;
         1: return -32768;
         2: return int'($urandom_range(0, 16)) - 8;
         default: return int'($urandom_range(0, 98303)) - 32768;
      endcase
   endfunction

   task drive_idle(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_func = FUNC_W'($urandom);
         req_coord_a = COORD_W'($urandom);
         req_coord_c = WIDE_W'($urandom);
      end
   endtask

   task send_primitive(logic [FUNC_W-1:0] func, int a, int b, int c, int d,
                       bit rel, bit loop, bit first, bit last);
      @(negedge clock);
      req_valid = 1'b1;
      req_func = func;
      req_coord_a = a[COORD_W-1:0];
      req_coord_b = b[COORD_W-1:0];
      req_coord_c = c[WIDE_W-1:0];
      req_coord_d = d[WIDE_W-1:0];
      req_relative_mode = rel;
      req_strip_loop = loop;
      req_first_point = first;
      req_last_point = last;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      vertex_board.note_primitive(func, a[COORD_W-1:0], b[COORD_W-1:0], c[WIDE_W-1:0],
                                  d[WIDE_W-1:0], rel, loop, first, last);
   endtask

   task send_with_gap(logic [FUNC_W-1:0] func, int a, int b, int c, int d,
                      bit rel, bit loop, bit first, bit last);
      if (!quiet_phase && $urandom_range(0, 3) == 0)
         drive_idle($urandom_range(1, 10));
      send_primitive(func, a, b, c, d, rel, loop, first, last);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         vertex_board.check_vertex(rsp_vertex_x, rsp_vertex_y, rsp_vertex_index,
                                   rsp_last_of_item);
   end

   initial begin : response_side
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin : request_side
      int random_count;
      int kind;
      int points;
      int a, b, c, d;
      bit loop;
      bit rel;
      bit r_rel, r_loop, r_first, r_last;
      int drain_cycles;

      vertex_board = new();
      quiet_phase = 1'b0;
      hold_off_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_RECT;
      req_coord_a = '0;
      req_coord_b = '0;
      req_coord_c = '0;
      req_coord_d = '0;
      req_relative_mode = 1'b0;
      req_strip_loop = 1'b0;
      req_first_point = 1'b0;
      req_last_point = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_with_gap(FUNC_RECT, 0, 0, 0, 0, 0, 0, 0, 0);
      send_with_gap(FUNC_RECT, 32767, -32768, 65535, -32768, 1, 1, 1, 1);
      send_with_gap(FUNC_RECT, -32768, 32767, -32768, 65535, 0, 0, 0, 0);
      send_with_gap(FUNC_BOX, -32768, 32767, 65535, -32768, 0, 0, 0, 0);
      send_with_gap(FUNC_BOX, 100, -5, -32768, 40000, 0, 0, 0, 0);
      send_with_gap(FUNC_SPAN, 32767, 0, 0, 0, 0, 0, 0, 0);
      send_with_gap(FUNC_SPAN, -32768, -1, 65535, 65535, 0, 0, 0, 0);
      send_with_gap(FUNC_SPAN, 5, 7, -32768, 0, 0, 0, 0, 0);
      send_with_gap(FUNC_SEGMENT, 10, 10, 20, 30, 0, 0, 0, 0);
      send_with_gap(FUNC_SEGMENT, 10, 10, -5, -7, 0, 0, 0, 0);
      send_with_gap(FUNC_SEGMENT, 5, 5, 5, 5, 0, 0, 0, 0);
      send_with_gap(FUNC_SEGMENT, 5, 5, 5, 9, 0, 0, 0, 0);
      send_with_gap(FUNC_SEGMENT, 0, 0, 32767, 65535, 0, 0, 0, 0);
      send_with_gap(FUNC_SEGMENT, 32767, -32768, -32768, 32767, 0, 0, 0, 0);
      send_with_gap(FUNC_LINE_POINT, 100, 200, 0, 0, 0, 0, 1, 0);
      send_with_gap(FUNC_LINE_POINT, 5, -3, 0, 0, 1, 0, 0, 0);
      send_with_gap(FUNC_LINE_POINT, 0, 0, 0, 0, 1, 0, 0, 1);
      send_with_gap(FUNC_LINE_POINT, 1, 1, 0, 0, 0, 0, 1, 0);
      send_with_gap(FUNC_LINE_POINT, 1, 1, 0, 0, 0, 1, 0, 1);
      send_with_gap(FUNC_LINE_POINT, 7, 8, 0, 0, 0, 0, 1, 1);
      send_with_gap(FUNC_LINE_POINT, 1, 1, 0, 0, 1, 0, 0, 0);
      send_with_gap(FUNC_LINE_POINT, 32767, 0, 0, 0, 1, 0, 0, 1);
      send_with_gap(FUNC_SEGMENT + 3'd1, 1, 2, 3, 4, 1, 1, 1, 1);
      send_with_gap(FUNC_LAST_CODE - 3'd1, -1, -1, -1, -1, 0, 0, 0, 0);
      send_with_gap(FUNC_LAST_CODE, 32767, 32767, 65535, 65535, 1, 0, 1, 0);

      hold_off_cycles = 80;
      random_count = 0;
      while (random_count < 100) begin
         quiet_phase = (random_count >= 85);
         kind = $urandom_range(0, 9);
         a = pick_coord();
         b = pick_coord();
         c = pick_wide();
         d = pick_wide();
         {r_rel, r_loop, r_first, r_last} = 4'($urandom);
         case (kind)
            0, 1: begin
               send_with_gap(FUNC_RECT, a, b, c, d, r_rel, r_loop, r_first, r_last);
               random_count++;
            end
            2: begin
               send_with_gap(FUNC_BOX, a, b, c, d, r_rel, r_loop, r_first, r_last);
               random_count++;
            end
            3: begin
               send_with_gap(FUNC_SPAN, a, b, c, d, r_rel, r_loop, r_first, r_last);
               random_count++;
            end
            4: begin
               if ($urandom_range(0, 2) == 0) c = a;
               if ($urandom_range(0, 2) == 0) d = b;
               send_with_gap(FUNC_SEGMENT, a, b, c, d, r_rel, r_loop, r_first, r_last);
               random_count++;
            end
            5, 6, 7: begin
               points = $urandom_range(2, 5);
               loop = 1'($urandom);
               for (int i = 0; i < points; i++) begin
                  rel = 1'($urandom);
                  if (rel && $urandom_range(0, 1) == 0) begin
                     a = int'($urandom_range(0, 8)) - 4;
                     b = int'($urandom_range(0, 8)) - 4;
                  end else if (!rel && $urandom_range(0, 3) == 0) begin
                     a = int'(req_coord_a);
                     b = int'(req_coord_b);
                  end else begin
                     a = pick_coord();
                     b = pick_coord();
                  end
                  send_with_gap(FUNC_LINE_POINT, a, b, pick_wide(), pick_wide(), rel, loop,
                                i == 0, i == points - 1);
                  random_count++;
               end
            end
            8: begin
               send_with_gap(FUNC_LINE_POINT, a, b, c, d, r_rel, r_loop, r_first, r_last);
               random_count++;
            end
            default: begin
               send_with_gap(FUNC_W'($urandom_range(FUNC_SEGMENT + 1, FUNC_LAST_CODE)),
                             a, b, c, d, r_rel, r_loop, r_first, r_last);
            end
         endcase
      end

      @(negedge clock);
      req_valid = 1'b0;
      drain_cycles = 0;
      while (vertex_board.pending_count() > 0 && drain_cycles < 4000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      if (vertex_board.pending_count() > 0)
         vertex_board.report($sformatf("%0d vertices never arrived",
                                       vertex_board.pending_count()));
      if (vertex_board.error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
